@@ hw/rtl/sfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the serial frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

   // Register map: register index taken from the word address
   localparam int unsigned ADDR_WIDTH = 3;
   localparam int unsigned DATA_WIDTH = 32;
   localparam logic        REG_SYNC_FIRST  = 1'b0;
   localparam logic        REG_SYNC_SECOND = 1'b1;

   // Register reset values
   localparam logic [7:0] SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'hBC;

   // Result kinds
   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // Configuration seen by the parser
   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
   } cfg_type;

   // One result beat
   typedef struct packed {
      logic       out_kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [7:0] frame_type;
      logic [7:0] frame_length;
      logic       check_ok;
   } rsp_type;

endpackage

@@ hw/rtl/sfd_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_csr
// APB-style register file holding the two sync byte values.
// ----------------------------------------------------------------------------
module sfd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [sfd_pkg::ADDR_WIDTH-1:0]   paddr,
   input  logic [sfd_pkg::DATA_WIDTH-1:0]   pwdata,
   output logic [sfd_pkg::DATA_WIDTH-1:0]   prdata,
   output logic                             pready,
   output sfd_pkg::cfg_type                 cfg
);
   import sfd_pkg::*;

   logic [7:0] sync_first_ff,  sync_first_in;
   logic [7:0] sync_second_ff, sync_second_in;
   logic       wr_en;
   logic       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[2];

   // Decode writes
   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_SYNC_FIRST:  sync_first_in  = pwdata[7:0];
            REG_SYNC_SECOND: sync_second_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Hold register values
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_sel)
         REG_SYNC_FIRST:  prdata = {{(DATA_WIDTH-8){1'b0}}, sync_first_ff};
         REG_SYNC_SECOND: prdata = {{(DATA_WIDTH-8){1'b0}}, sync_second_ff};
         default:         prdata = '0;
      endcase
   end

   assign cfg.sync_first  = sync_first_ff;
   assign cfg.sync_second = sync_second_ff;

endmodule

@@ hw/rtl/sfd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_parser
// Frame state machine: sync hunt, header capture, payload and check byte.
// ----------------------------------------------------------------------------
module sfd_parser (
   input  logic             clock,
   input  logic             reset,
   input  sfd_pkg::cfg_type cfg,
   input  logic             byte_valid,
   input  logic [7:0]       byte_in,
   output logic             res_valid,
   output sfd_pkg::rsp_type res
);
   import sfd_pkg::*;

   typedef enum logic [2:0] {
      PH_SYNC1 = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_TYPE  = 3'd2,
      PH_LEN   = 3'd3,
      PH_BODY  = 3'd4
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] type_ff,  type_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] xor_ff,   xor_in;
   logic       in_body;

   assign in_body = (count_ff < length_ff);

   // Next state and result for one byte
   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      length_in = length_ff;
      count_in  = count_ff;
      xor_in    = xor_ff;
      res_valid = 1'b0;
      res       = '0;
      res.frame_type   = type_ff;
      res.frame_length = length_ff;
      if (byte_valid) begin
         case (phase_ff)
            PH_SYNC1: begin
               if (byte_in == cfg.sync_first) begin
                  phase_in = PH_SYNC2;
               end else begin
                  phase_in = PH_SYNC1;
                  count_in = '0;
                  xor_in   = '0;
               end
            end
            PH_SYNC2: begin
               if (byte_in == cfg.sync_second) begin
                  phase_in = PH_TYPE;
               end else begin
                  phase_in = PH_SYNC1;
                  count_in = '0;
                  xor_in   = '0;
               end
            end
            PH_TYPE: begin
               type_in  = byte_in;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               length_in = byte_in;
               count_in  = '0;
               xor_in    = '0;
               phase_in  = PH_BODY;
            end
            PH_BODY: begin
               res_valid = 1'b1;
               if (in_body) begin
                  // pass payload byte on, fold it into the checksum
                  res.out_kind   = KIND_PAYLOAD;
                  res.data_byte  = byte_in;
                  res.byte_index = count_ff;
                  xor_in         = xor_ff ^ byte_in;
                  count_in       = count_ff + 8'd1;
               end else begin
                  // check byte: empty frames always pass
                  res.out_kind = KIND_FRAME_END;
                  res.check_ok = (length_ff == 8'd0) || (xor_ff == byte_in);
                  phase_in     = PH_SYNC1;
                  count_in     = '0;
                  xor_in       = '0;
               end
            end
            default: begin
               phase_in = PH_SYNC1;
               count_in = '0;
               xor_in   = '0;
            end
         endcase
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC1;
         type_ff   <= '0;
         length_ff <= '0;
         count_ff  <= '0;
         xor_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         xor_ff    <= xor_in;
      end
   end

endmodule

@@ hw/rtl/sfd_skid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_skid
// Two-entry result register: output stage plus one skid entry.
// ----------------------------------------------------------------------------
module sfd_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfd_pkg::rsp_type push_data,
   output logic             space,
   output logic             out_valid,
   input  logic             out_ready,
   output sfd_pkg::rsp_type out_data
);
   import sfd_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop       = main_valid_ff & out_ready;
   assign space     = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Advance beats through the output stage
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff) begin
         main_valid_in = push;
         main_in       = push_data;
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         // stalled output: park the new beat
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

@@ hw/rtl/serial_frame_deframer_xor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_deframer_xor
// Sync-header deframer with length byte and XOR check byte.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_ready   | req_rx_byte
//   rsp     | out       | rsp_valid / rsp_ready   | kind, data, index, type, length, ok
//   csr     | in        | psel/penable/pready     | sync_first @0x0, sync_second @0x4
//
// One byte is taken per cycle while req_ready is high; the parser state updates in the accept cycle.
// A result is registered in the output stage (or the skid entry while rsp stalls) before it appears on rsp.
// A skid entry lets one more beat in while rsp stalls; req_ready drops only
// when both output entries are full, and then every byte waits, header or not.
// Reset is synchronous and returns the parser to the sync hunt.
// ----------------------------------------------------------------------------
module serial_frame_deframer_xor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_out_kind,
   output logic [7:0]                     rsp_data_byte,
   output logic [7:0]                     rsp_byte_index,
   output logic [7:0]                     rsp_frame_type,
   output logic [7:0]                     rsp_frame_length,
   output logic                           rsp_check_ok,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sfd_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [sfd_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [sfd_pkg::DATA_WIDTH-1:0] prdata,
   output logic                           pready
);
   import sfd_pkg::*;

   cfg_type cfg;
   rsp_type res;
   rsp_type out_data;
   logic    res_valid;
   logic    accept;
   logic    space;

   assign req_ready = space;
   assign accept    = req_valid & space;

   sfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .byte_valid (accept),
      .byte_in    (req_rx_byte),
      .res_valid  (res_valid),
      .res        (res)
   );

   sfd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (accept & res_valid),
      .push_data (res),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   // Unpack the result beat
   assign rsp_out_kind     = out_data.out_kind;
   assign rsp_data_byte    = out_data.data_byte;
   assign rsp_byte_index   = out_data.byte_index;
   assign rsp_frame_type   = out_data.frame_type;
   assign rsp_frame_length = out_data.frame_length;
   assign rsp_check_ok     = out_data.check_ok;

endmodule
